>>> hdl/cia402_pkg.sv
// Package for the CiA 402 drive state controller.
// Holds drive state codes, status decode masks, control word constants and the item type.
`timescale 1ns / 1ps

package cia402_pkg;

  typedef enum logic [3:0] {
    DS_START       = 4'd0,
    DS_NOT_READY   = 4'd1,
    DS_SW_DISABLED = 4'd2,
    DS_READY       = 4'd3,
    DS_SWITCHED_ON = 4'd4,
    DS_OP_ENABLED  = 4'd5,
    DS_QUICK_STOP  = 4'd6,
    DS_FAULT_REACT = 4'd7,
    DS_FAULT       = 4'd8,
    DS_UNDEFINED   = 4'd9
  } drive_state_t;

  typedef enum logic [1:0] {
    CFG_AUTO_TRANS  = 2'd0,
    CFG_AUTO_FRESET = 2'd1,
    CFG_RESET_CMD   = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    REQ_ZERO    = 2'd0,
    REQ_NONZERO = 2'd1,
    REQ_NAN     = 2'd2
  } reset_req_t;

  localparam logic [15:0] SW_MASK_A    = 16'h004F;
  localparam logic [15:0] SW_MASK_B    = 16'h006F;
  localparam logic [15:0] SW_NOT_READY = 16'h0000;
  localparam logic [15:0] SW_DISABLED  = 16'h0040;
  localparam logic [15:0] SW_READY     = 16'h0021;
  localparam logic [15:0] SW_SWITCHED  = 16'h0023;
  localparam logic [15:0] SW_OP_EN     = 16'h0027;
  localparam logic [15:0] SW_QSTOP     = 16'h0007;
  localparam logic [15:0] SW_FREACT    = 16'h000F;
  localparam logic [15:0] SW_FAULT     = 16'h0008;

  localparam logic [15:0] CW_SHUTDOWN_MASK = 16'h007E;
  localparam logic [15:0] CW_SHUTDOWN      = 16'h0006;
  localparam logic [15:0] CW_SWITCH_MASK   = 16'h0077;
  localparam logic [15:0] CW_SWITCH_ON     = 16'h0007;
  localparam logic [15:0] CW_ENABLE_MASK   = 16'h007F;
  localparam logic [15:0] CW_ENABLE_OP     = 16'h000F;
  localparam logic [15:0] CW_KEEP_ENABLED  = 16'h001F;
  localparam logic [15:0] CW_FRESET_MASK   = 16'h00FF;
  localparam logic [15:0] CW_FAULT_RESET   = 16'h0080;

  typedef struct packed {
    logic        op;
    logic [15:0] stat_word;
    logic [15:0] command_word;
    logic [1:0]  reset_request;
    logic        operational;
  } in_item_t;

endpackage

>>> hdl/cia402_ifs.sv
// Valid/ready channel interfaces for the CiA 402 drive state controller.
// Depends on nothing; payload fields follow the item and result layouts.
`timescale 1ns / 1ps

interface cia402_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] stat_word;
  logic [15:0] command_word;
  logic [1:0]  reset_request;
  logic        operational;

  modport source (output valid, op, stat_word, command_word, reset_request, operational,
                  input ready);
  modport sink (input valid, op, stat_word, command_word, reset_request, operational,
                output ready);
endinterface

interface cia402_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] ctrl_word_out;
  logic [3:0]  drive_state;
  logic        initialized;

  modport source (output valid, ctrl_word_out, drive_state, initialized, input ready);
  modport sink (input valid, ctrl_word_out, drive_state, initialized, output ready);
endinterface

>>> hdl/cia402_in_stage.sv
// Input register stage: captures one transaction and holds it until the core takes it.
// Depends on cia402_pkg.
`timescale 1ns / 1ps

module cia402_in_stage
  import cia402_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  output logic     s1_valid,
  input  logic     s1_take,
  output in_item_t s1_item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign in_ready  = !valid_r || s1_take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

>>> hdl/cia402_core.sv
// Drive state tracking, control word rewrite and result register.
// Depends on cia402_pkg.
`timescale 1ns / 1ps

module cia402_core
  import cia402_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic        cfg_wdata,
  input  logic        s1_valid,
  output logic        s1_take,
  input  in_item_t    s1_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] ctrl_word_out,
  output logic [3:0]  drive_state,
  output logic        initialized
);

  logic         auto_trans_r;
  logic         auto_freset_r;
  logic         reset_cmd_r;

  drive_state_t state_r,   state_nxt;
  logic [15:0]  prev_sw_r, prev_sw_nxt;
  logic         pending_r, pending_nxt;
  logic         seen_r,    seen_nxt;
  logic         ready_r,   ready_nxt;

  logic         out_valid_r;
  logic [15:0]  cw_out_r;
  logic [15:0]  cw_nxt;

  function automatic drive_state_t decode_status(input logic [15:0] sw);
    logic [15:0] a;
    logic [15:0] b;
    a = sw & SW_MASK_A;
    b = sw & SW_MASK_B;
    if (a == SW_NOT_READY)     return DS_NOT_READY;
    else if (a == SW_DISABLED) return DS_SW_DISABLED;
    else if (b == SW_READY)    return DS_READY;
    else if (b == SW_SWITCHED) return DS_SWITCHED_ON;
    else if (b == SW_OP_EN)    return DS_OP_ENABLED;
    else if (b == SW_QSTOP)    return DS_QUICK_STOP;
    else if (a == SW_FREACT)   return DS_FAULT_REACT;
    else if (a == SW_FAULT)    return DS_FAULT;
    else                       return DS_UNDEFINED;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_trans_r  <= 1'b0;
      auto_freset_r <= 1'b0;
      reset_cmd_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AUTO_TRANS:  auto_trans_r  <= cfg_wdata;
        CFG_AUTO_FRESET: auto_freset_r <= cfg_wdata;
        CFG_RESET_CMD:   reset_cmd_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s1_take = s1_valid && (!out_valid_r || out_ready);

  always_comb begin
    logic seen_tmp;
    state_nxt   = state_r;
    prev_sw_nxt = prev_sw_r;
    pending_nxt = pending_r;
    seen_nxt    = seen_r;
    ready_nxt   = ready_r;
    cw_nxt      = '0;
    seen_tmp    = seen_r;
    if (!s1_item.op) begin
      if (s1_item.stat_word != prev_sw_r) begin
        state_nxt = decode_status(s1_item.stat_word);
      end
      prev_sw_nxt = s1_item.stat_word;
      ready_nxt   = (state_nxt == DS_OP_ENABLED);
    end else begin
      cw_nxt = s1_item.command_word;
      if (s1_item.operational) begin
        if (reset_cmd_r) begin
          if (s1_item.reset_request == REQ_ZERO) begin
            seen_tmp = 1'b0;
          end
          seen_nxt = seen_tmp;
          if (!seen_tmp && s1_item.reset_request != REQ_ZERO
              && s1_item.reset_request != REQ_NAN) begin
            seen_nxt    = 1'b1;
            pending_nxt = 1'b1;
          end
        end
        if (auto_trans_r) begin
          case (state_r)
            DS_SW_DISABLED: cw_nxt = (s1_item.command_word & CW_SHUTDOWN_MASK) | CW_SHUTDOWN;
            DS_READY:       cw_nxt = (s1_item.command_word & CW_SWITCH_MASK) | CW_SWITCH_ON;
            DS_SWITCHED_ON,
            DS_QUICK_STOP:  cw_nxt = (s1_item.command_word & CW_ENABLE_MASK) | CW_ENABLE_OP;
            DS_OP_ENABLED:  cw_nxt = s1_item.command_word | CW_KEEP_ENABLED;
            DS_FAULT: begin
              if (auto_freset_r || pending_nxt) begin
                pending_nxt = 1'b0;
                cw_nxt = (s1_item.command_word & CW_FRESET_MASK) | CW_FAULT_RESET;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= DS_START;
      prev_sw_r   <= '0;
      pending_r   <= 1'b0;
      seen_r      <= 1'b0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_take) begin
        state_r   <= state_nxt;
        prev_sw_r <= prev_sw_nxt;
        pending_r <= pending_nxt;
        seen_r    <= seen_nxt;
        ready_r   <= ready_nxt;
      end
      if (s1_take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      cw_out_r <= cw_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign ctrl_word_out = cw_out_r;
  assign drive_state   = state_r;
  assign initialized   = ready_r;

endmodule

>>> hdl/cia402_drive_state_controller.sv
// Top level of the CiA 402 drive state controller.
// Depends on cia402_pkg, cia402_ifs, cia402_in_stage and cia402_core.
//
// Takes one transaction per clock on in_chan while out_chan is not stalled, and returns one
// result per transaction on out_chan, in order, from the result register. The path
// is an input register, one pass of decode and rewrite logic, and the result register
// that also holds the drive state; throughput is one transaction per cycle unless stalled.
// A status word transaction updates the tracked drive state and returns ctrl_word_out of zero;
// a control word transaction returns the command word, rewritten toward operation enabled
// when auto transitions are on and the bus is operational. Configuration registers are
// written through cfg_we/cfg_index/cfg_wdata and should only change while the block is idle.
`timescale 1ns / 1ps

module cia402_drive_state_controller
  import cia402_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic         cfg_wdata,
  cia402_in_if.sink    in_chan,
  cia402_out_if.source out_chan
);

  in_item_t in_item;
  in_item_t s1_item;
  logic     s1_valid;
  logic     s1_take;

  assign in_item.op            = in_chan.op;
  assign in_item.stat_word     = in_chan.stat_word;
  assign in_item.command_word  = in_chan.command_word;
  assign in_item.reset_request = in_chan.reset_request;
  assign in_item.operational   = in_chan.operational;

  cia402_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_item  (in_item),
    .s1_valid (s1_valid),
    .s1_take  (s1_take),
    .s1_item  (s1_item)
  );

  cia402_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s1_valid      (s1_valid),
    .s1_take       (s1_take),
    .s1_item       (s1_item),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .ctrl_word_out (out_chan.ctrl_word_out),
    .drive_state   (out_chan.drive_state),
    .initialized   (out_chan.initialized)
  );

endmodule

>>> hdl/cia402_chk.sv
// Port-level checker for the CiA 402 drive state controller, with its bind.
// Depends on cia402_pkg and the top level.
`timescale 1ns / 1ps

module cia402_chk
  import cia402_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] ctrl_word_out,
  input logic [3:0]  drive_state,
  input logic        initialized
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_init_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (initialized == (drive_state == DS_OP_ENABLED)))
    else $error("initialized disagrees with drive state");

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while result side is empty");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(ctrl_word_out)
      && $stable(drive_state) && $stable(initialized))
    else $error("stalled result changed");

endmodule

bind cia402_drive_state_controller cia402_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .ctrl_word_out (out_chan.ctrl_word_out),
  .drive_state   (out_chan.drive_state),
  .initialized   (out_chan.initialized)
);
